// ===== hw/rtl/pfa_pkg.sv =====
// Package for the page frame allocator: default sizes, item kind and
// status codes, and the table write-enable group.
// No dependencies.
package pfa_pkg;

  localparam int MAX_PAGES_DEF  = 1024;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int ADDR_BITS_DEF  = 52;

  // Item kinds
  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_RESERVE = 3'd1;
  localparam logic [2:0] KIND_POP     = 3'd2;
  localparam logic [2:0] KIND_RUN     = 3'd3;
  localparam logic [2:0] KIND_FREE    = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FREE  = 3'd1;
  localparam logic [2:0] ST_NO_RUN   = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_BAD      = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  // Write enables of the three table fields
  typedef struct packed {
    logic frame;
    logic free;
    logic next;
  } pfa_we_t;

endpackage

// ===== hw/rtl/pfa_if.sv =====
// Valid/ready channel interfaces of the page frame allocator.
// Depends on pfa_pkg for default widths.
interface pfa_in_if
  import pfa_pkg::*;
#(
  parameter int ADDR_W = ADDR_BITS_DEF,
  parameter int CNT_W  = $clog2(MAX_PAGES_DEF + 1)
);
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] length;
  logic [ADDR_W-1:0] end_addr;
  logic [CNT_W-1:0]  run_pages;

  modport source (output valid, kind, addr, length, end_addr, run_pages, input ready);
  modport sink   (input valid, kind, addr, length, end_addr, run_pages, output ready);
endinterface

interface pfa_out_if
  import pfa_pkg::*;
#(
  parameter int ADDR_W = ADDR_BITS_DEF,
  parameter int IDX_W  = $clog2(MAX_PAGES_DEF),
  parameter int CNT_W  = $clog2(MAX_PAGES_DEF + 1)
);
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] page_addr;
  logic [IDX_W-1:0]  page_index;
  logic [CNT_W-1:0]  pages_done;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  total_count;

  modport source (output valid, status, page_addr, page_index, pages_done, free_count,
                  total_count, input ready);
  modport sink   (input valid, status, page_addr, page_index, pages_done, free_count,
                  total_count, output ready);
endinterface

// ===== hw/rtl/pfa_table.sv =====
// Page table memories: frame number, free mark and next link per entry.
// One registered read port and one write port. Depends on pfa_pkg.
module pfa_table
  import pfa_pkg::*;
#(
  parameter int DEPTH = MAX_PAGES_DEF,
  parameter int IDX_W = $clog2(MAX_PAGES_DEF),
  parameter int FW    = ADDR_BITS_DEF - PAGE_SHIFT_DEF,
  parameter int CNT_W = $clog2(MAX_PAGES_DEF + 1)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [FW-1:0]    rd_frame,
  output logic             rd_free,
  output logic [CNT_W-1:0] rd_next,
  input  pfa_we_t          we,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [FW-1:0]    wr_frame,
  input  logic             wr_free,
  input  logic [CNT_W-1:0] wr_next
);

  logic [FW-1:0]    frame_mem [DEPTH];
  logic             free_mem  [DEPTH];
  logic [CNT_W-1:0] next_mem  [DEPTH];

  // Write the selected fields
  always_ff @(posedge clk) begin
    if (we.frame) frame_mem[wr_addr] <= wr_frame;
    if (we.free)  free_mem[wr_addr]  <= wr_free;
    if (we.next)  next_mem[wr_addr]  <= wr_next;
  end

  // Read one entry, hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_frame <= frame_mem[rd_addr];
      rd_free  <= free_mem[rd_addr];
      rd_next  <= next_mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pfa_cmp.sv =====
// Shared compare unit of the allocator sequencer: equal and less-than.
// Depends on pfa_pkg for the default width.
module pfa_cmp
  import pfa_pkg::*;
#(
  parameter int AW = ADDR_BITS_DEF - PAGE_SHIFT_DEF + 1
) (
  input  logic [AW-1:0] op_a,
  input  logic [AW-1:0] op_b,
  output logic          eq,
  output logic          lt
);
  assign eq = (op_a == op_b);
  assign lt = (op_a < op_b);
endmodule

// ===== hw/rtl/page_frame_allocator.sv =====
// Page frame allocator: page table with a LIFO free list, run by a sequencer.
// Add appends pages one by one; reserve walks the free list; allocate page pops the
// list head; allocate run scans the table, then walks the list to unlink the run;
// free run searches the table for each page in turn. One item at a time.
// Each step is bound by the single table read port and the shared compare unit.
// Reset (rst_n, synchronous) empties the list and counts; no clearing pass.
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pfa_in_if.sink     in_ch,
  pfa_out_if.source  out_ch
);

  localparam int FW    = ADDR_BITS - PAGE_SHIFT;
  localparam int AW    = FW + 1;
  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam logic [CNT_W-1:0] NULL_IDX = CNT_W'(MAX_PAGES);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_ADD       = 15'b000000000000010,
    S_WALK_RD   = 15'b000000000000100,
    S_WALK_LO   = 15'b000000000001000,
    S_WALK_EV   = 15'b000000000010000,
    S_WALK_END  = 15'b000000000100000,
    S_POP_RD    = 15'b000000001000000,
    S_POP_EV    = 15'b000000010000000,
    S_RUN_RD    = 15'b000000100000000,
    S_RUN_EV    = 15'b000001000000000,
    S_FREE_NEXT = 15'b000010000000000,
    S_FREE_RD   = 15'b000100000000000,
    S_FREE_EV   = 15'b001000000000000,
    S_RESP      = 15'b010000000000000,
    S_SPARE     = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [CNT_W-1:0] head_r, head_nxt, et_r, et_nxt, ft_r, ft_nxt;
  logic             out_valid_r, out_valid_nxt;
  // Work registers
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cur_r, cur_nxt, steps_r, steps_nxt;
  logic [CNT_W-1:0] newhead_r, newhead_nxt, tail_r, tail_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] run_r, run_nxt, done_r, done_nxt;
  logic [AW-1:0]    sf_r, sf_nxt, ef_r, ef_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]    prev_inc_r, prev_inc_nxt, fcur_r, fcur_nxt;
  logic [IDX_W-1:0] first_r, first_nxt, last_r, last_nxt, rstart_r, rstart_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [FW-1:0]    rframe_r, rframe_nxt, pframe_r, pframe_nxt;
  logic             reverse_r, reverse_nxt, ge_r, ge_nxt, aligned_r, aligned_nxt;
  logic [2:0]       st_r, st_nxt;
  // Output payload
  logic [2:0]           o_status_r;
  logic [ADDR_BITS-1:0] o_addr_r;
  logic [IDX_W-1:0]     o_idx_r;
  logic [CNT_W-1:0]     o_done_r, o_free_r, o_total_r;
  logic                 load_out;

  // Table and compare unit connections
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [FW-1:0]    rd_frame, wr_frame;
  logic             rd_free, wr_free;
  logic [CNT_W-1:0] rd_next, wr_next, run_new;
  pfa_we_t          we;
  logic [AW-1:0]    op_a, op_b;
  logic             c_eq, c_lt, in_rng;
  logic [ADDR_BITS-1:0] sum_w;

  pfa_table #(.DEPTH(MAX_PAGES), .IDX_W(IDX_W), .FW(FW), .CNT_W(CNT_W)) u_table (
    .clk, .rd_en, .rd_addr, .rd_frame, .rd_free, .rd_next,
    .we, .wr_addr, .wr_frame, .wr_free, .wr_next
  );

  pfa_cmp #(.AW(AW)) u_cmp (.op_a, .op_b, .eq(c_eq), .lt(c_lt));

  assign in_ch.ready = (state_r == S_IDLE);
  assign sum_w       = in_ch.addr + in_ch.length;

  // Route operands of the shared compare unit
  always_comb begin
    op_a = {1'b0, rd_frame};
    op_b = lo_r;
    case (state_r)
      S_ADD:     begin op_a = sf_r; op_b = ef_r; end
      S_WALK_LO: op_b = lo_r;
      S_WALK_EV: op_b = hi_r;
      S_RUN_EV:  op_b = prev_inc_r;
      S_FREE_EV: op_b = fcur_r;
      default:   op_b = lo_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;  head_nxt = head_r;  et_nxt = et_r;  ft_nxt = ft_r;
    cnt_nxt = cnt_r;  cur_nxt = cur_r;  steps_nxt = steps_r;  newhead_nxt = newhead_r;
    tail_nxt = tail_r;  k_nxt = k_r;  j_nxt = j_r;  run_nxt = run_r;  done_nxt = done_r;
    sf_nxt = sf_r;  ef_nxt = ef_r;  lo_nxt = lo_r;  hi_nxt = hi_r;
    prev_inc_nxt = prev_inc_r;  fcur_nxt = fcur_r;  first_nxt = first_r;
    last_nxt = last_r;  rstart_nxt = rstart_r;  pidx_nxt = pidx_r;
    rframe_nxt = rframe_r;  pframe_nxt = pframe_r;  reverse_nxt = reverse_r;
    ge_nxt = ge_r;  aligned_nxt = aligned_r;  st_nxt = st_r;
    rd_en = 1'b0;  rd_addr = cur_r[IDX_W-1:0];
    we = '0;  wr_addr = cur_r[IDX_W-1:0];  wr_frame = sf_r[FW-1:0];
    wr_free = 1'b0;  wr_next = NULL_IDX;
    in_rng = 1'b0;  run_new = '0;
    load_out = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cnt_nxt = in_ch.run_pages;  st_nxt = ST_OK;  pframe_nxt = '0;
          pidx_nxt = '0;  done_nxt = '0;
          cur_nxt = head_r;  steps_nxt = '0;  newhead_nxt = NULL_IDX;  tail_nxt = NULL_IDX;
          k_nxt = '0;  j_nxt = '0;  run_nxt = '0;
          sf_nxt = AW'(in_ch.addr >> PAGE_SHIFT) + AW'(|in_ch.addr[PAGE_SHIFT-1:0]);
          ef_nxt = AW'(sum_w >> PAGE_SHIFT);
          lo_nxt = AW'(in_ch.addr >> PAGE_SHIFT);
          hi_nxt = AW'(in_ch.end_addr >> PAGE_SHIFT) + AW'(|in_ch.end_addr[PAGE_SHIFT-1:0]);
          fcur_nxt = AW'(in_ch.addr >> PAGE_SHIFT);
          aligned_nxt = ~|in_ch.addr[PAGE_SHIFT-1:0];
          state_nxt = S_RESP;
          case (in_ch.kind)
            KIND_ADD: begin
              if (in_ch.length == '0 || sum_w < in_ch.addr) st_nxt = ST_BAD;
              else state_nxt = S_ADD;
            end
            KIND_RESERVE: begin
              reverse_nxt = 1'b1;
              state_nxt = S_WALK_RD;
            end
            KIND_POP: begin
              if (head_r >= et_r) st_nxt = ST_NO_FREE;
              else state_nxt = S_POP_RD;
            end
            KIND_RUN: begin
              if (in_ch.run_pages == '0) st_nxt = ST_ZERO;
              else state_nxt = S_RUN_RD;
            end
            KIND_FREE: begin
              if (in_ch.run_pages == '0) st_nxt = ST_ZERO;
              else state_nxt = S_FREE_NEXT;
            end
            default: st_nxt = ST_BAD;
          endcase
        end
      end

      // Append one page per cycle and push it on the list
      S_ADD: begin
        if (!c_lt) begin
          state_nxt = S_RESP;
        end else if (et_r == NULL_IDX) begin
          st_nxt = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          we = '{frame: 1'b1, free: 1'b1, next: 1'b1};
          wr_addr = et_r[IDX_W-1:0];  wr_free = 1'b1;  wr_next = head_r;
          head_nxt = et_r;  et_nxt = et_r + ONE;  ft_nxt = ft_r + ONE;
          done_nxt = done_r + ONE;  sf_nxt = sf_r + AW'(1);
        end
      end

      // Walk the free list, dropping entries in range and relinking the rest
      S_WALK_RD: begin
        if (cur_r < et_r && steps_r < NULL_IDX) begin
          rd_en = 1'b1;
          state_nxt = S_WALK_LO;
        end else begin
          state_nxt = S_WALK_END;
        end
      end
      S_WALK_LO: begin
        ge_nxt = ~c_lt;
        state_nxt = S_WALK_EV;
      end
      S_WALK_EV: begin
        if (reverse_r) in_rng = ge_r && c_lt;
        else in_rng = (cur_r[IDX_W-1:0] >= first_r) && (cur_r[IDX_W-1:0] <= last_r);
        steps_nxt = steps_r + ONE;
        cur_nxt = rd_next;
        if (in_rng) begin
          we = '{frame: 1'b0, free: 1'b1, next: 1'b1};
          wr_free = 1'b0;  wr_next = NULL_IDX;
          done_nxt = done_r + ONE;
        end else if (reverse_r) begin
          we.next = 1'b1;  wr_next = newhead_r;  newhead_nxt = cur_r;
        end else begin
          if (tail_r == NULL_IDX) begin
            newhead_nxt = cur_r;
          end else begin
            we.next = 1'b1;  wr_addr = tail_r[IDX_W-1:0];  wr_next = cur_r;
          end
          tail_nxt = cur_r;
        end
        state_nxt = S_WALK_RD;
      end
      S_WALK_END: begin
        head_nxt = newhead_r;
        if (reverse_r) begin
          ft_nxt = ft_r - done_r;
        end else begin
          ft_nxt = ft_r - cnt_r;
          done_nxt = cnt_r;
          if (tail_r != NULL_IDX) begin
            we.next = 1'b1;  wr_addr = tail_r[IDX_W-1:0];  wr_next = NULL_IDX;
          end
        end
        state_nxt = S_RESP;
      end

      // Pop the list head
      S_POP_RD: begin
        rd_en = 1'b1;  rd_addr = head_r[IDX_W-1:0];
        state_nxt = S_POP_EV;
      end
      S_POP_EV: begin
        we = '{frame: 1'b0, free: 1'b1, next: 1'b1};
        wr_addr = head_r[IDX_W-1:0];  wr_free = 1'b0;  wr_next = NULL_IDX;
        head_nxt = rd_next;  ft_nxt = ft_r - ONE;
        pframe_nxt = rd_frame;  pidx_nxt = head_r[IDX_W-1:0];  done_nxt = ONE;
        state_nxt = S_RESP;
      end

      // Scan the table for a free, contiguous run
      S_RUN_RD: begin
        if (k_r < et_r) begin
          rd_en = 1'b1;  rd_addr = k_r[IDX_W-1:0];
          state_nxt = S_RUN_EV;
        end else begin
          st_nxt = ST_NO_RUN;
          state_nxt = S_RESP;
        end
      end
      S_RUN_EV: begin
        if (!rd_free) run_new = '0;
        else if (run_r != '0 && c_eq) run_new = run_r + ONE;
        else run_new = ONE;
        run_nxt = run_new;
        prev_inc_nxt = {1'b0, rd_frame} + AW'(1);
        if (run_new == ONE) begin
          rstart_nxt = k_r[IDX_W-1:0];  rframe_nxt = rd_frame;
        end
        if (run_new == cnt_r) begin
          first_nxt = (run_new == ONE) ? k_r[IDX_W-1:0] : rstart_r;
          last_nxt = k_r[IDX_W-1:0];
          pidx_nxt = first_nxt;
          pframe_nxt = (run_new == ONE) ? rd_frame : rframe_r;
          reverse_nxt = 1'b0;
          state_nxt = S_WALK_RD;
        end else begin
          k_nxt = k_r + ONE;
          state_nxt = S_RUN_RD;
        end
      end

      // Free a run: search the table for each page in turn
      S_FREE_NEXT: begin
        k_nxt = '0;
        if (j_r == cnt_r) begin
          state_nxt = S_RESP;
        end else if (!aligned_r || fcur_r[FW]) begin
          st_nxt = ST_IGNORED;
          j_nxt = j_r + ONE;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        if (k_r < et_r) begin
          rd_en = 1'b1;  rd_addr = k_r[IDX_W-1:0];
          state_nxt = S_FREE_EV;
        end else begin
          st_nxt = ST_IGNORED;
          j_nxt = j_r + ONE;  fcur_nxt = fcur_r + AW'(1);
          state_nxt = S_FREE_NEXT;
        end
      end
      S_FREE_EV: begin
        if (c_eq) begin
          if (!rd_free) begin
            we = '{frame: 1'b0, free: 1'b1, next: 1'b1};
            wr_addr = k_r[IDX_W-1:0];  wr_free = 1'b1;  wr_next = head_r;
            head_nxt = k_r;  ft_nxt = ft_r + ONE;  done_nxt = done_r + ONE;
          end else begin
            st_nxt = ST_IGNORED;
          end
          j_nxt = j_r + ONE;  fcur_nxt = fcur_r + AW'(1);
          state_nxt = S_FREE_NEXT;
        end else begin
          k_nxt = k_r + ONE;
          state_nxt = S_FREE_RD;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out | (out_valid_r & ~out_ch.ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_IDX;
      et_r        <= '0;
      ft_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      et_r        <= et_nxt;
      ft_r        <= ft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Work and payload registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;  cur_r <= cur_nxt;  steps_r <= steps_nxt;
    newhead_r <= newhead_nxt;  tail_r <= tail_nxt;  k_r <= k_nxt;  j_r <= j_nxt;
    run_r <= run_nxt;  done_r <= done_nxt;  sf_r <= sf_nxt;  ef_r <= ef_nxt;
    lo_r <= lo_nxt;  hi_r <= hi_nxt;  prev_inc_r <= prev_inc_nxt;  fcur_r <= fcur_nxt;
    first_r <= first_nxt;  last_r <= last_nxt;  rstart_r <= rstart_nxt;
    pidx_r <= pidx_nxt;  rframe_r <= rframe_nxt;  pframe_r <= pframe_nxt;
    reverse_r <= reverse_nxt;  ge_r <= ge_nxt;  aligned_r <= aligned_nxt;  st_r <= st_nxt;
    if (load_out) begin
      o_status_r <= st_r;
      o_addr_r   <= {pframe_r, {PAGE_SHIFT{1'b0}}};
      o_idx_r    <= pidx_r;
      o_done_r   <= done_r;
      o_free_r   <= ft_r;
      o_total_r  <= et_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.page_addr   = o_addr_r;
  assign out_ch.page_index  = o_idx_r;
  assign out_ch.pages_done  = o_done_r;
  assign out_ch.free_count  = o_free_r;
  assign out_ch.total_count = o_total_r;

  // Checks on the counts and the result path
  a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n) ft_r <= et_r)
    else $error("free count exceeds table size");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n) et_r <= NULL_IDX)
    else $error("table size beyond capacity");
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NULL_IDX) || (head_r < et_r))
    else $error("list head outside table");
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside response state");

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for page_frame_allocator: directed, random and table-full items
// checked field by field against a behavioral copy of the page table kept here.
// Depends on pfa_pkg and the pfa_in_if / pfa_out_if channel interfaces.
`timescale 1ns / 1ps

module testbench;
  import pfa_pkg::*;

  localparam int          TBL_DEPTH  = MAX_PAGES_DEF;
  localparam int          PG_SHIFT   = PAGE_SHIFT_DEF;
  localparam logic [63:0] ADDR_MASK  = (64'd1 << ADDR_BITS_DEF) - 1;
  localparam logic [63:0] PG_LOW     = (64'd1 << PG_SHIFT) - 1;
  localparam longint      CYCLE_CAP  = 20000000;
  localparam int          RAND_ITEMS = 450;
  localparam int          DRAIN_WAIT = 64;
  // Kinds the block does not define
  localparam logic [2:0]  KIND_SPARE5 = 3'd5;
  localparam logic [2:0]  KIND_SPARE6 = 3'd6;
  localparam logic [2:0]  KIND_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [51:0] addr;
    logic [51:0] length;
    logic [51:0] end_addr;
    logic [10:0] run_pages;
  } alloc_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [51:0] page_addr;
    logic [9:0]  page_index;
    logic [10:0] pages_done;
    logic [10:0] free_count;
    logic [10:0] total_count;
  } alloc_rsp_t;

  logic clk;
  logic rst_n;
  longint cycles;
  int errors;
  bit quiet;          // no idling on either side while set
  int rx_hold;        // long receiver hold-off requested by a test
  alloc_rsp_t pending_rsp[$];

  // Shadow page table
  logic [39:0] frame_tbl [TBL_DEPTH];
  bit          free_tbl  [TBL_DEPTH];
  int          link_tbl  [TBL_DEPTH];
  int          keep_idx  [TBL_DEPTH];
  int          list_top;
  int          n_entries;
  int          n_free;

  pfa_in_if  in_ch ();
  pfa_out_if out_ch ();

  page_frame_allocator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Push one entry on the shadow free list
  task automatic list_push(input int idx);
    free_tbl[idx] = 1'b1;
    link_tbl[idx] = list_top;
    list_top = idx;
    n_free++;
  endtask

  // Drop list entries whose key lies in [lo, hi), relink the rest
  task automatic list_rebuild(input logic [63:0] lo, input logic [63:0] hi,
                              input bit by_frame, input bit reverse, output int removed);
    int kept, steps, cur, nxt, idx;
    logic [63:0] key;
    kept = 0;
    removed = 0;
    steps = 0;
    cur = list_top;
    while (cur < n_entries && steps < TBL_DEPTH) begin
      key = by_frame ? 64'(frame_tbl[cur]) : 64'(cur);
      nxt = link_tbl[cur];
      if (key >= lo && key < hi) begin
        free_tbl[cur] = 1'b0;
        link_tbl[cur] = TBL_DEPTH;
        removed++;
      end else begin
        keep_idx[kept] = cur;
        kept++;
      end
      cur = nxt;
      steps++;
    end
    list_top = TBL_DEPTH;
    for (int k = 0; k < kept; k++) begin
      idx = reverse ? keep_idx[k] : keep_idx[kept - 1 - k];
      link_tbl[idx] = list_top;
      list_top = idx;
    end
  endtask

  // Apply one request to the shadow table and form its response
  task automatic predict_alloc(input alloc_req_t rq, output alloc_rsp_t rs);
    logic [63:0] a, len, e, sum, sf, ef, f, maxf, base, run;
    logic [63:0] paddr;
    int cnt, removed, k, first, idx;
    bit found, ok, aligned;
    logic [2:0] st;
    int pidx, done;
    a = 64'(rq.addr);
    len = 64'(rq.length);
    e = 64'(rq.end_addr);
    cnt = int'(rq.run_pages);
    st = ST_OK;
    paddr = '0;
    pidx = 0;
    done = 0;
    case (rq.kind)
      KIND_ADD: begin
        sum = (a + len) & ADDR_MASK;
        if (len == 0 || sum < a) begin
          st = ST_BAD;
        end else begin
          sf = (a >> PG_SHIFT) + ((a & PG_LOW) != 0);
          ef = sum >> PG_SHIFT;
          while (sf < ef) begin
            if (n_entries >= TBL_DEPTH) begin
              st = ST_FULL;
              break;
            end
            frame_tbl[n_entries] = sf[39:0];
            list_push(n_entries);
            n_entries++;
            done++;
            sf++;
          end
        end
      end
      KIND_RESERVE: begin
        sf = a >> PG_SHIFT;
        ef = (e >> PG_SHIFT) + ((e & PG_LOW) != 0);
        list_rebuild(sf, ef, 1'b1, 1'b1, removed);
        n_free -= removed;
        done = removed;
      end
      KIND_POP: begin
        if (list_top >= n_entries) begin
          st = ST_NO_FREE;
        end else begin
          idx = list_top;
          list_top = link_tbl[idx];
          free_tbl[idx] = 1'b0;
          link_tbl[idx] = TBL_DEPTH;
          n_free--;
          paddr = 64'(frame_tbl[idx]) << PG_SHIFT;
          pidx = idx;
          done = 1;
        end
      end
      KIND_RUN: begin
        if (cnt == 0) begin
          st = ST_ZERO;
        end else begin
          run = 0;
          found = 1'b0;
          for (k = 0; k < n_entries; k++) begin
            if (!free_tbl[k]) run = 0;
            else if (run > 0 && 64'(frame_tbl[k]) == 64'(frame_tbl[k-1]) + 1) run++;
            else run = 1;
            if (run == cnt) begin
              found = 1'b1;
              break;
            end
          end
          if (!found) begin
            st = ST_NO_RUN;
          end else begin
            first = k + 1 - cnt;
            list_rebuild(64'(first), 64'(k) + 1, 1'b0, 1'b0, removed);
            n_free -= cnt;
            paddr = 64'(frame_tbl[first]) << PG_SHIFT;
            pidx = first;
            done = cnt;
          end
        end
      end
      KIND_FREE: begin
        if (cnt == 0) begin
          st = ST_ZERO;
        end else begin
          maxf = ADDR_MASK >> PG_SHIFT;
          base = a >> PG_SHIFT;
          aligned = (a & PG_LOW) == 0;
          for (int j = 0; j < cnt; j++) begin
            f = base + j;
            ok = 1'b0;
            if (aligned && f <= maxf) begin
              for (k = 0; k < n_entries; k++) begin
                if (64'(frame_tbl[k]) == f) begin
                  if (!free_tbl[k]) begin
                    list_push(k);
                    ok = 1'b1;
                  end
                  break;
                end
              end
            end
            if (ok) done++;
            else st = ST_IGNORED;
          end
        end
      end
      default: st = ST_BAD;
    endcase
    rs.status = st;
    rs.page_addr = paddr[51:0];
    rs.page_index = pidx[9:0];
    rs.pages_done = done[10:0];
    rs.free_count = n_free[10:0];
    rs.total_count = n_entries[10:0];
  endtask

  // Offer one item, hold it until accepted, then predict its response
  task automatic send_req(input logic [2:0] kind, input logic [51:0] addr,
                          input logic [51:0] length, input logic [51:0] end_addr,
                          input logic [10:0] run_pages);
    int gap;
    alloc_req_t rq;
    alloc_rsp_t rs;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.addr <= addr;
    in_ch.length <= length;
    in_ch.end_addr <= end_addr;
    in_ch.run_pages <= run_pages;
    do @(posedge clk); while (!in_ch.ready);
    rq.kind = kind;
    rq.addr = addr;
    rq.length = length;
    rq.end_addr = end_addr;
    rq.run_pages = run_pages;
    predict_alloc(rq, rs);
    pending_rsp.push_back(rs);
  endtask

  function automatic logic [51:0] rand52();
    return 52'({$urandom, $urandom});
  endfunction

  // Receiver: random stalls per item, plus a long hold-off on request
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    alloc_rsp_t x;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response, status %0d", out_ch.status);
        errors++;
      end else begin
        x = pending_rsp.pop_front();
        if (out_ch.status !== x.status) begin
          $error("status: expected %0d, got %0d", x.status, out_ch.status);
          errors++;
        end
        if (out_ch.page_addr !== x.page_addr) begin
          $error("page_addr: expected %h, got %h", x.page_addr, out_ch.page_addr);
          errors++;
        end
        if (out_ch.page_index !== x.page_index) begin
          $error("page_index: expected %0d, got %0d", x.page_index, out_ch.page_index);
          errors++;
        end
        if (out_ch.pages_done !== x.pages_done) begin
          $error("pages_done: expected %0d, got %0d", x.pages_done, out_ch.pages_done);
          errors++;
        end
        if (out_ch.free_count !== x.free_count) begin
          $error("free_count: expected %0d, got %0d", x.free_count, out_ch.free_count);
          errors++;
        end
        if (out_ch.total_count !== x.total_count) begin
          $error("total_count: expected %0d, got %0d", x.total_count, out_ch.total_count);
          errors++;
        end
      end
    end
  end

  // Empty table, bad items, small ranges and the edge cases of each kind
  task automatic test_directed();
    send_req(KIND_POP, '0, '0, '0, '0);
    send_req(KIND_RUN, '0, '0, '0, 11'd1);
    send_req(KIND_RUN, '0, '0, '0, '0);
    send_req(KIND_FREE, 52'h1000, '0, '0, '0);
    send_req(KIND_SPARE5, '1, '1, '1, '1);
    send_req(KIND_SPARE6, '0, '0, '0, '0);
    send_req(KIND_SPARE7, '0, '0, '0, '0);
    send_req(KIND_ADD, 52'h100000, '0, '0, '0);
    send_req(KIND_ADD, '1, '1, '0, '0);
    // unaligned base and end round inward
    send_req(KIND_ADD, 52'h100123, 52'h5000, '0, '0);
    send_req(KIND_ADD, 52'h200000, 52'h3000, '0, '0);
    send_req(KIND_POP, '0, '0, '0, '0);
    send_req(KIND_RUN, '0, '0, '0, 11'd2);
    send_req(KIND_RUN, '0, '0, '0, 11'd1024);
    send_req(KIND_FREE, 52'h100000, '0, '0, 11'd1024);
    send_req(KIND_FREE, 52'h101800, '0, '0, 11'd2);
    send_req(KIND_FREE, 52'hFFFFFFFFFF000, '0, '0, 11'd3);
    send_req(KIND_FREE, 52'h102000, '0, '0, 11'd1);
    // inverted reserve overlaps nothing
    send_req(KIND_RESERVE, 52'h105000, '0, 52'h101000, '0);
    send_req(KIND_RESERVE, 52'h101fff, '0, 52'h103001, '0);
    send_req(KIND_RESERVE, '0, '0, '1, '0);
    send_req(KIND_FREE, 52'h100000, '0, '0, 11'd8);
    send_req(KIND_FREE, 52'h200000, '0, '0, 11'd3);
  endtask

  // Mostly well-formed items in a small frame window, some noise
  task automatic test_random();
    int pick;
    logic [51:0] a, e, len;
    logic [10:0] n;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 90 == 40) quiet = 1'b1;
      if (i % 90 == 60) quiet = 1'b0;
      // long receiver hold-off while items keep coming
      if (i == 200) rx_hold = 400;
      pick = $urandom_range(0, 99);
      a = 52'h100000 + 52'($urandom_range(0, 255) << PG_SHIFT);
      if ($urandom_range(0, 3) == 0) a = a + 52'($urandom_range(1, 4095));
      if (pick < 18) begin
        len = 52'($urandom_range(1, 6 << PG_SHIFT));
        send_req(KIND_ADD, a, len, rand52(), 11'(rand52()));
      end else if (pick < 28) begin
        e = $urandom_range(0, 7) ? a + 52'($urandom_range(0, 4 << PG_SHIFT))
                                 : a - 52'($urandom_range(0, 4 << PG_SHIFT));
        send_req(KIND_RESERVE, a, rand52(), e, 11'(rand52()));
      end else if (pick < 52) begin
        send_req(KIND_POP, rand52(), rand52(), rand52(), 11'(rand52()));
      end else if (pick < 72) begin
        n = $urandom_range(0, 12) ? 11'($urandom_range(1, 4)) : 11'($urandom_range(0, 1024));
        send_req(KIND_RUN, rand52(), rand52(), rand52(), n);
      end else if (pick < 93) begin
        n = $urandom_range(0, 15) ? 11'($urandom_range(1, 5)) : 11'd0;
        send_req(KIND_FREE, a, rand52(), rand52(), n);
      end else begin
        // noise: full-width fields, adds forced to wrap or be empty
        pick = $urandom_range(0, 7);
        case (pick)
          KIND_ADD:
            send_req(KIND_ADD, ADDR_MASK[51:0] - 52'($urandom_range(0, 65535)),
                     $urandom_range(0, 1) ? (rand52() | 52'h8000000000000) : 52'd0,
                     rand52(), '0);
          KIND_FREE:
            send_req(KIND_FREE, rand52(), rand52(), rand52(), 11'($urandom_range(0, 3)));
          default:
            send_req(pick[2:0], rand52(), rand52(), rand52(),
                     11'($urandom_range(0, 1024)));
        endcase
      end
    end
  endtask

  // Fill the table to capacity, then exercise a full table
  task automatic test_table_full();
    send_req(KIND_ADD, 52'h40000000, 52'h8000000000000, '0, '0);
    send_req(KIND_ADD, 52'h900000, 52'h4000, '0, '0);
    send_req(KIND_POP, '0, '0, '0, '0);
    send_req(KIND_RUN, '0, '0, '0, 11'd1024);
    send_req(KIND_RUN, '0, '0, '0, 11'd3);
    send_req(KIND_FREE, 52'h40000000, '0, '0, 11'd2);
    send_req(KIND_RESERVE, '0, '0, '1, '0);
    send_req(KIND_POP, '0, '0, '0, '0);
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    quiet = 1'b0;
    rx_hold = 0;
    list_top = TBL_DEPTH;
    n_entries = 0;
    n_free = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_POP;
    in_ch.addr <= '0;
    in_ch.length <= '0;
    in_ch.end_addr <= '0;
    in_ch.run_pages <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_table_full();
    in_ch.valid <= 1'b0;

    // drain outstanding responses
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_if.sv
hw/rtl/pfa_table.sv
hw/rtl/pfa_cmp.sv
hw/rtl/page_frame_allocator.sv
dv/testbench.sv
